// File: hw/rtl/assert_macros.svh
// Assertion macros for the ring buffer RTL, included by the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mcorb_pkg.sv
// Package with sizes, codes and types of the multichannel ring buffer.
package mcorb_pkg;

   localparam int CHANNELS = 8;
   localparam int DEPTH    = 1024;
   localparam int CH_W     = $clog2(CHANNELS);
   localparam int PTR_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int ADDR_W   = CH_W + PTR_W;
   localparam int CTX_W    = CNT_W + 2 * PTR_W;

   localparam logic       CMD_WRITE = 1'b0;
   localparam logic       CMD_READ  = 1'b1;

   localparam logic [2:0] ST_WRITE_DONE = 3'd0;
   localparam logic [2:0] ST_DELIVERED  = 3'd1;
   localparam logic [2:0] ST_EMPTY      = 3'd2;
   localparam logic [2:0] ST_ESCAPE     = 3'd3;
   localparam logic [2:0] ST_DISABLED   = 3'd4;

   localparam logic [7:0] ESCAPE_BYTE = 8'h01;

   typedef struct packed {
      logic [CNT_W-1:0] fill;
      logic [PTR_W-1:0] rp;
      logic [PTR_W-1:0] wp;
   } ctx_type;

   typedef struct packed {
      logic            wr_en;
      logic [CH_W-1:0] wr_addr;
      ctx_type         wr_data;
      logic            rd_en;
      logic [CH_W-1:0] rd_addr;
   } ctx_req_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } byte_req_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/multichannel_overwrite_ring_buffer_top.sv
// Top level of the multichannel overwrite-oldest ring buffer with escape decoding.
//
//   Channel   Ports                                    Handshake
//   request   req_command, req_channel, req_data_in     start, busy
//   response  rsp_status, rsp_data_out                  rsp_strobe (one cycle)
//   control   csr_write_data                            csr_write_enable
//
// A write, an empty read or a disabled transaction passes the pointer table read
// and the response register; a read that pops a byte also passes the byte store
// read, which follows the pointer table read, each RAM having registered read data.
// busy stays high until the response is loaded, so one transaction is in flight.
// Reset marks every channel empty through per-channel valid bits; byte store
// contents stay undefined until written. The response side cannot stall.
module multichannel_overwrite_ring_buffer_top
   import mcorb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic            csr_write_data,
   input  logic            start,
   output logic            busy,
   input  logic            req_command,
   input  logic [CH_W-1:0] req_channel,
   input  logic [7:0]      req_data_in,
   output logic            rsp_strobe,
   output logic [2:0]      rsp_status,
   output logic [7:0]      rsp_data_out
);

   logic               csr_enable_ff, csr_enable_in;
   ctx_req_type        ctx_req;
   logic [CTX_W-1:0]   ctx_rd_data;
   byte_req_type       byte_req;
   logic [7:0]         byte_rd_data;

   assign csr_enable_in = csr_write_enable ? csr_write_data : csr_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_enable_ff <= 1'b0;
      end else begin
         csr_enable_ff <= csr_enable_in;
      end
   end

   mcorb_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .enable       (csr_enable_ff),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_channel  (req_channel),
      .req_data_in  (req_data_in),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .ctx_req      (ctx_req),
      .ctx_rd_data  (ctx_rd_data),
      .byte_req     (byte_req),
      .byte_rd_data (byte_rd_data)
   );

   mcorb_ram #(
      .WIDTH  (CTX_W),
      .ADDR_W (CH_W)
   ) u_ctx_ram (
      .clock   (clock),
      .wr_en   (ctx_req.wr_en),
      .wr_addr (ctx_req.wr_addr),
      .wr_data (ctx_req.wr_data),
      .rd_en   (ctx_req.rd_en),
      .rd_addr (ctx_req.rd_addr),
      .rd_data (ctx_rd_data)
   );

   mcorb_ram #(
      .WIDTH  (8),
      .ADDR_W (ADDR_W)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_req.wr_en),
      .wr_addr (byte_req.wr_addr),
      .wr_data (byte_req.wr_data),
      .rd_en   (byte_req.rd_en),
      .rd_addr (byte_req.rd_addr),
      .rd_data (byte_rd_data)
   );

endmodule

// File: hw/rtl/mcorb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mcorb_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 13
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [(1 << ADDR_W)];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mcorb_ctrl.sv
// Sequencer: pointer table read-modify-write, byte access and escape decoding.
`include "assert_macros.svh"

module mcorb_ctrl
   import mcorb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [CH_W-1:0]    req_channel,
   input  logic [7:0]         req_data_in,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_data_out,
   output ctx_req_type        ctx_req,
   input  logic [CTX_W-1:0]   ctx_rd_data,
   output byte_req_type       byte_req,
   input  logic [7:0]         byte_rd_data
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CTX  = 3'b010,
      S_BYTE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic               cmd_ff, cmd_in;
   logic [CH_W-1:0]    ch_ff, ch_in;
   logic [7:0]         din_ff, din_in;
   logic               esc_ff, esc_in;
   logic [CHANNELS-1:0] ctx_valid_ff, ctx_valid_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;

   ctx_type            ctx_cur;
   ctx_type            ctx_new;
   logic [PTR_W-1:0]   wp_next;
   logic [PTR_W-1:0]   rp_next;

   always_comb begin
      ctx_cur  = ctx_valid_ff[ch_ff] ? ctx_type'(ctx_rd_data) : '0;
      wp_next  = ptr_next(ctx_cur.wp);
      rp_next  = ptr_next(ctx_cur.rp);
      ctx_new  = ctx_cur;

      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ch_in         = ch_ff;
      din_in        = din_ff;
      esc_in        = esc_ff;
      ctx_valid_in  = ctx_valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      ctx_req       = '0;
      byte_req      = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in          = req_command;
               ch_in           = req_channel;
               din_in          = req_data_in;
               ctx_req.rd_en   = 1'b1;
               ctx_req.rd_addr = req_channel;
               state_in        = S_CTX;
            end
         end
         S_CTX: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_data_in   = 8'h00;
            if (!enable) begin
               rsp_status_in = ST_DISABLED;
            end else if (cmd_ff == CMD_WRITE) begin
               rsp_status_in    = ST_WRITE_DONE;
               byte_req.wr_en   = 1'b1;
               byte_req.wr_addr = {ch_ff, ctx_cur.wp};
               byte_req.wr_data = din_ff;
               ctx_new.wp       = wp_next;
               if (ctx_cur.fill == CNT_W'(DEPTH)) begin
                  ctx_new.rp = wp_next;
               end else begin
                  ctx_new.fill = ctx_cur.fill + CNT_W'(1);
               end
               ctx_req.wr_en       = 1'b1;
               ctx_req.wr_addr     = ch_ff;
               ctx_req.wr_data     = ctx_new;
               ctx_valid_in[ch_ff] = 1'b1;
            end else if (ctx_cur.fill == '0) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_strobe_in       = 1'b0;
               byte_req.rd_en      = 1'b1;
               byte_req.rd_addr    = {ch_ff, ctx_cur.rp};
               ctx_new.rp          = rp_next;
               ctx_new.fill        = ctx_cur.fill - CNT_W'(1);
               ctx_req.wr_en       = 1'b1;
               ctx_req.wr_addr     = ch_ff;
               ctx_req.wr_data     = ctx_new;
               ctx_valid_in[ch_ff] = 1'b1;
               state_in            = S_BYTE;
            end
         end
         S_BYTE: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            if (esc_ff) begin
               esc_in        = 1'b0;
               rsp_status_in = ST_DELIVERED;
               rsp_data_in   = byte_rd_data - 8'h01;
            end else if (byte_rd_data == ESCAPE_BYTE) begin
               esc_in        = 1'b1;
               rsp_status_in = ST_ESCAPE;
               rsp_data_in   = 8'h00;
            end else begin
               rsp_status_in = ST_DELIVERED;
               rsp_data_in   = byte_rd_data;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         esc_ff        <= 1'b0;
         ctx_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         esc_ff        <= esc_in;
         ctx_valid_ff  <= ctx_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ch_ff         <= ch_in;
      din_ff        <= din_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;

   `ASSERT_NEXT(a_start_reads_ctx, clock, reset, start && !busy, state_ff == S_CTX,
      "accepted transaction did not reach the pointer table stage")
   `ASSERT_IMPLIES(a_ctx_wr_stage, clock, reset, ctx_req.wr_en,
      state_ff == S_CTX && enable, "pointer table written outside its stage")
   `ASSERT_IMPLIES(a_byte_rd_stage, clock, reset, byte_req.rd_en,
      state_ff == S_CTX && cmd_ff == CMD_READ, "byte read issued outside a read")
   `ASSERT_IMPLIES(a_escape_reported, clock, reset, $rose(esc_ff),
      rsp_strobe_ff && rsp_status_ff == ST_ESCAPE, "escape set without escape status")

endmodule

// File: tb/sv/tb_multichannel_overwrite_ring_buffer_checker.sv
// Checker: predicts ring buffer responses from observed transactions and compares them.
module tb_multichannel_overwrite_ring_buffer_checker
   import mcorb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic            csr_write_data,
   input  logic            start,
   input  logic            busy,
   input  logic            req_command,
   input  logic [CH_W-1:0] req_channel,
   input  logic [7:0]      req_data_in,
   input  logic            rsp_strobe,
   input  logic [2:0]      rsp_status,
   input  logic [7:0]      rsp_data_out,
   output int              fail_count,
   output int              pending_count
);

   typedef struct {
      logic [2:0] status;
      logic [7:0] data;
   } ring_reply_type;

   ring_reply_type   expected_replies[$];
   logic [7:0]       ring_mem [CHANNELS*DEPTH];
   logic [PTR_W-1:0] wr_ptr [CHANNELS];
   logic [PTR_W-1:0] rd_ptr [CHANNELS];
   logic [CNT_W-1:0] fill_level [CHANNELS];
   logic             esc_pending;
   logic             ring_enable;
   int               mismatch_count = 0;

   function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
      return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic ring_reply_type predict_reply(input logic cmd,
                                                    input logic [CH_W-1:0] ch,
                                                    input logic [7:0] din);
      ring_reply_type r;
      logic [7:0]     popped;
      int             idx;
      r.status = ST_WRITE_DONE;
      r.data   = '0;
      if (!ring_enable) begin
         r.status = ST_DISABLED;
      end else if (cmd == CMD_WRITE) begin
         if (int'(ch) < CHANNELS) begin
            idx = int'(ch) * DEPTH + int'(wr_ptr[ch]);
            ring_mem[idx] = din;
            wr_ptr[ch] = step_ptr(wr_ptr[ch]);
            if (fill_level[ch] >= CNT_W'(DEPTH)) begin
               rd_ptr[ch] = wr_ptr[ch];
            end else begin
               fill_level[ch] = fill_level[ch] + 1'b1;
            end
         end
      end else if (int'(ch) >= CHANNELS || fill_level[ch] == '0) begin
         r.status = ST_EMPTY;
      end else begin
         idx = int'(ch) * DEPTH + int'(rd_ptr[ch]);
         popped = ring_mem[idx];
         rd_ptr[ch] = step_ptr(rd_ptr[ch]);
         fill_level[ch] = fill_level[ch] - 1'b1;
         if (esc_pending) begin
            esc_pending = 1'b0;
            r.status = ST_DELIVERED;
            r.data = popped - 8'd1;
         end else if (popped == ESCAPE_BYTE) begin
            esc_pending = 1'b1;
            r.status = ST_ESCAPE;
         end else begin
            r.status = ST_DELIVERED;
            r.data = popped;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch_channels
      ring_reply_type want;
      if (reset) begin
         expected_replies.delete();
         for (int c = 0; c < CHANNELS; c++) begin
            wr_ptr[c]     = '0;
            rd_ptr[c]     = '0;
            fill_level[c] = '0;
         end
         esc_pending = 1'b0;
         ring_enable = 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf(
                  "response with no transaction outstanding: status %0d data 0x%0h",
                  rsp_status, rsp_data_out));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf(
                     "response status mismatch: got 0x%0h, expected 0x%0h",
                     rsp_status, want.status));
               end
               if (rsp_data_out !== want.data) begin
                  report_mismatch($sformatf(
                     "response data_out mismatch: got 0x%0h, expected 0x%0h",
                     rsp_data_out, want.data));
               end
            end
         end
         if (csr_write_enable) begin
            ring_enable = csr_write_data;
         end
         if (start && !busy) begin
            expected_replies.push_back(predict_reply(req_command, req_channel, req_data_in));
         end
      end
      fail_count    <= mismatch_count;
      pending_count <= expected_replies.size();
   end

endmodule

// File: tb/sv/tb_multichannel_overwrite_ring_buffer_top.sv
// Testbench top: drives transactions and configuration, and gives the verdict.
module tb_multichannel_overwrite_ring_buffer_top;
   import mcorb_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 150;
   localparam int READ_BACK    = 16;

   logic            clock;
   logic            reset            = 1'b1;
   logic            csr_write_enable = 1'b0;
   logic            csr_write_data   = 1'b0;
   logic            start            = 1'b0;
   logic            busy;
   logic            req_command      = CMD_WRITE;
   logic [CH_W-1:0] req_channel      = '0;
   logic [7:0]      req_data_in      = '0;
   logic            rsp_strobe;
   logic [2:0]      rsp_status;
   logic [7:0]      rsp_data_out;
   int              fail_count;
   int              pending_count;
   int              burst_left  = 0;
   logic            steady_mode = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   multichannel_overwrite_ring_buffer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_channel      (req_channel),
      .req_data_in      (req_data_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out)
   );

   tb_multichannel_overwrite_ring_buffer_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_channel      (req_channel),
      .req_data_in      (req_data_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("** multichannel_overwrite_ring_buffer_top: FAILED **");
      $finish;
   end

   task automatic send_transaction(input logic cmd, input logic [CH_W-1:0] ch,
                                   input logic [7:0] din);
      start       <= 1'b1;
      req_command <= cmd;
      req_channel <= ch;
      req_data_in <= din;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic pace_burst();
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (!steady_mode) idle_cycles($urandom_range(1, 6));
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_enable(input logic value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] escape_rich_byte();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return ESCAPE_BYTE;
      if (pick == 3) return 8'h00;
      if (pick == 4) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [CH_W-1:0] any_channel();
      return CH_W'($urandom_range(0, CHANNELS - 1));
   endfunction

   function automatic logic any_command();
      return ($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ;
   endfunction

   initial begin : stimulus
      int               sent;
      int               next_toggle;
      int               n_wr;
      int               n_rd;
      int               n_flood;
      logic [CH_W-1:0]  ch;
      logic [CH_W-1:0]  rch;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_transaction(CMD_WRITE, 3'd0, 8'hAA);
      send_transaction(CMD_READ, 3'd0, 8'h55);
      set_enable(1'b1);
      send_transaction(CMD_READ, 3'd0, 8'h00);
      send_transaction(CMD_READ, 3'd7, 8'hFF);
      send_transaction(CMD_WRITE, 3'd0, 8'h00);
      send_transaction(CMD_WRITE, 3'd0, 8'hFF);
      send_transaction(CMD_WRITE, 3'd7, ESCAPE_BYTE);
      send_transaction(CMD_WRITE, 3'd7, 8'h00);
      send_transaction(CMD_WRITE, 3'd7, ESCAPE_BYTE);
      send_transaction(CMD_WRITE, 3'd7, ESCAPE_BYTE);
      send_transaction(CMD_WRITE, 3'd3, ESCAPE_BYTE);
      send_transaction(CMD_WRITE, 3'd3, 8'h80);
      send_transaction(CMD_WRITE, 3'd5, 8'h7F);
      send_transaction(CMD_READ, 3'd0, 8'h00);
      send_transaction(CMD_READ, 3'd0, 8'h00);
      send_transaction(CMD_READ, 3'd7, 8'h00);
      send_transaction(CMD_READ, 3'd0, 8'h00);
      send_transaction(CMD_READ, 3'd7, 8'h00);
      send_transaction(CMD_READ, 3'd7, 8'h00);
      send_transaction(CMD_READ, 3'd3, 8'h00);
      send_transaction(CMD_READ, 3'd7, 8'h00);
      send_transaction(CMD_READ, 3'd5, 8'h00);
      send_transaction(CMD_READ, 3'd3, 8'h00);

      // overflow one ring so the oldest bytes get overwritten, then pop the oldest few
      drain();
      ch = any_channel();
      n_flood = DEPTH + $urandom_range(1, 40);
      for (int k = 0; k < n_flood; k++) begin
         send_transaction(CMD_WRITE, ch, escape_rich_byte());
         pace_burst();
      end
      for (int k = 0; k < READ_BACK; k++) begin
         send_transaction(CMD_READ, ch, 8'($urandom_range(0, 255)));
         pace_burst();
      end

      sent = 0;
      next_toggle = $urandom_range(40, 80);
      while (sent < RANDOM_ITEMS) begin
         if (sent >= next_toggle) begin
            set_enable(1'b0);
            steady_mode = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(5, 15)) begin
               send_transaction(any_command(), any_channel(), 8'($urandom_range(0, 255)));
               pace_burst();
            end
            set_enable(1'b1);
            next_toggle = sent + $urandom_range(40, 80);
         end
         if ($urandom_range(0, 9) < 6) begin
            ch = any_channel();
            n_wr = $urandom_range(1, 8);
            n_rd = n_wr + $urandom_range(0, 2);
            for (int k = 0; k < n_wr; k++) begin
               send_transaction(CMD_WRITE, ch, escape_rich_byte());
               pace_burst();
            end
            for (int k = 0; k < n_rd; k++) begin
               rch = ($urandom_range(0, 7) == 0) ? any_channel() : ch;
               send_transaction(CMD_READ, rch, 8'($urandom_range(0, 255)));
               pace_burst();
            end
            sent += n_wr + n_rd;
         end else begin
            send_transaction(any_command(), any_channel(), 8'($urandom_range(0, 255)));
            pace_burst();
            sent++;
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("** multichannel_overwrite_ring_buffer_top: PASSED **");
      end else begin
         $display("** multichannel_overwrite_ring_buffer_top: FAILED **");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/mcorb_pkg.sv
hw/rtl/mcorb_ram.sv
hw/rtl/mcorb_ctrl.sv
hw/rtl/multichannel_overwrite_ring_buffer_top.sv
tb/sv/tb_multichannel_overwrite_ring_buffer_checker.sv
tb/sv/tb_multichannel_overwrite_ring_buffer_top.sv
